// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check an implication on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// check that a condition is followed by another on the next clock edge
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ===== hw/rtl/p2d_pkg.sv =====
// Package for the posit to double decoder: types and constants.
// No dependencies.
`timescale 1ns / 1ps
package p2d_pkg;
   localparam int unsigned MAX_ES     = 4;
   localparam int unsigned FRAC_BITS  = 52;
   localparam int unsigned EXP_BITS   = 11;
   localparam int unsigned DBL_BIAS   = 1023;
   localparam int unsigned WORD_BITS  = 16;
   localparam int unsigned ES_BITS    = 3;
   localparam logic [63:0] QNAN_BITS  = 64'h7FF8_0000_0000_0000;

   typedef enum logic [1:0] {
      CLASS_NORMAL = 2'd0,
      CLASS_ZERO   = 2'd1,
      CLASS_NAR    = 2'd2
   } value_class_type;
endpackage

// ===== hw/rtl/p2d_req_if.sv =====
// Valid/ready channel interface for posit words in.
// Depends on p2d_pkg.
`timescale 1ns / 1ps
interface p2d_req_if;
   import p2d_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] posit_word;
   modport source (output valid, output posit_word, input ready);
   modport sink (input valid, input posit_word, output ready);
endinterface

// ===== hw/rtl/p2d_rsp_if.sv =====
// Valid/ready channel interface for decoded double words.
// Depends on p2d_pkg.
`timescale 1ns / 1ps
interface p2d_rsp_if;
   import p2d_pkg::*;
   logic        valid;
   logic        ready;
   logic [63:0] double_word;
   logic [1:0]  value_class;
   modport source (output valid, output double_word, output value_class, input ready);
   modport sink (input valid, input double_word, input value_class, output ready);
endinterface

// ===== hw/rtl/posit_to_double_decoder.sv =====
// Top level of the posit to double decoder.
// Depends on p2d_pkg, p2d_req_if, p2d_rsp_if, p2d_decode, assert_macros.svh.
//
// Use: posit words arrive on req (valid/ready), decoded doubles leave on
// rsp together with a class code (ordinary, zero, NaR). The csr port sets
// the number of exponent bits; write it only while the block is idle.
// An accepted word moves through the input register, then the result
// register, whose valid flag drives rsp valid. Throughput: one word per
// cycle while rsp is not stalled, set by the single decode pass between
// the two registers. Reset clears both valid flags and exp_size to zero.
// When the receiver stalls, the result register holds its word; the input
// register fills, then holds; req.ready falls only while both are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module posit_to_double_decoder #(
   parameter int unsigned POSIT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   p2d_req_if.sink                  req,
   p2d_rsp_if.source                rsp,
   input  logic                     csr_write_enable,
   input  logic [p2d_pkg::ES_BITS-1:0] csr_write_data
);
   import p2d_pkg::*;

   logic [ES_BITS-1:0]    exp_size_ff;
   logic                  in_valid_ff;
   logic [POSIT_BITS-1:0] in_word_ff;
   logic                  out_valid_ff;
   logic [63:0]           out_word_ff;
   logic [1:0]            out_class_ff;
   logic [63:0]           dec_word;
   logic [1:0]            dec_class;
   logic                  out_load;

   // advance the result register when empty or being taken
   assign out_load  = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || out_load;

   p2d_decode #(.POSIT_BITS(POSIT_BITS)) u_dec (
      .posit(in_word_ff), .exp_size(exp_size_ff),
      .double_word(dec_word), .value_class(dec_class)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_size_ff  <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable)
            exp_size_ff <= csr_write_data;
         if (req.ready)
            in_valid_ff <= req.valid;
         if (out_load)
            out_valid_ff <= in_valid_ff;
      end
      if (req.ready && req.valid)
         in_word_ff <= req.posit_word[POSIT_BITS-1:0];
      if (out_load && in_valid_ff) begin
         out_word_ff  <= dec_word;
         out_class_ff <= dec_class;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.double_word = out_word_ff;
   assign rsp.value_class = out_class_ff;

   `ASSERT_CLK(a_hold_full, clock, reset,
      (in_valid_ff && out_valid_ff && !rsp.ready) |-> !req.ready)
   `ASSERT_NEXT(a_out_moves, clock, reset, in_valid_ff && !out_valid_ff, out_valid_ff)
   `ASSERT_CLK(a_class_ok, clock, reset,
      out_valid_ff |-> (out_class_ff != 2'd3))
endmodule

// ===== hw/rtl/p2d_decode.sv =====
// Combinational posit field decode: sign, regime, exponent, fraction.
// Depends on p2d_pkg.
`timescale 1ns / 1ps
module p2d_decode #(
   parameter int unsigned POSIT_BITS = 16
) (
   input  logic [POSIT_BITS-1:0]   posit,
   input  logic [p2d_pkg::ES_BITS-1:0] exp_size,
   output logic [63:0]             double_word,
   output logic [1:0]              value_class
);
   import p2d_pkg::*;
   localparam int unsigned N = POSIT_BITS;
   localparam int unsigned CW = $clog2(N + 1);

   logic [N-1:0]  mag;
   logic [N-1:0]  norm;
   logic [CW-1:0] run;
   logic          first;
   logic          sgn;
   logic          found;
   logic [2:0]    es;
   logic [N+3:0]  body;
   logic [3:0]    ex;
   logic [N-1:0]  fr;
   logic signed [15:0] k;
   logic signed [15:0] e;
   logic [FRAC_BITS-1:0] frac;

   always_comb begin
      sgn   = posit[N-1];
      mag   = sgn ? (~posit + 1'b1) : posit;
      first = mag[N-2];
      // count the run with a priority search, one step per bit
      run   = CW'(N - 1);
      found = 1'b0;
      for (int i = N - 2; i >= 0; i--) begin
         if (!found && mag[i] != first) begin
            run   = CW'(N - 2 - i);
            found = 1'b1;
         end
      end
      es = (exp_size > ES_BITS'(MAX_ES)) ? ES_BITS'(MAX_ES) : exp_size;
      // drop sign, run and terminator; left-align what remains
      norm = (mag << run) << 2;
      body = {norm, 4'b0};
      ex   = 4'(body[N+3 -: 4] >> (4 - es));
      // drop the exponent bits; the fraction stays left-aligned
      fr   = norm << es;
      k    = first ? 16'(signed'({1'b0, run})) - 16'sd1
                   : -16'(signed'({1'b0, run}));
      e    = 16'(signed'({1'b0, ex})) + (k <<< es) + 16'sd1023;
      frac = '0;
      frac[FRAC_BITS-1 -: N] = fr;
      if (posit == '0) begin
         double_word = '0;
         value_class = CLASS_ZERO;
      end else if (posit == {1'b1, {(N-1){1'b0}}}) begin
         double_word = QNAN_BITS;
         value_class = CLASS_NAR;
      end else begin
         double_word = {sgn, e[EXP_BITS-1:0], frac};
         value_class = CLASS_NORMAL;
      end
   end
endmodule

// ===== dv/posit_to_double_decoder_tb.sv =====
// Self-checking testbench for the posit to double decoder.
// Depends on p2d_pkg, p2d_req_if, p2d_rsp_if and posit_to_double_decoder.
`timescale 1ns / 1ps

class double_word_scoreboard;
   typedef struct {
      logic [63:0] double_word;
      logic [1:0]  value_class;
   } decoded_type;

   decoded_type pending_q[$];
   logic [2:0] exp_size = 3'd0;
   int mismatches = 0;

   // Decode one posit word of 16 bits at the current exponent size.
   function decoded_type decode(logic [15:0] posit_word);
      decoded_type d;
      logic [15:0] w;
      logic sign;
      logic first;
      int run, es, rem, fbits, k, e;
      logic [15:0] r, ex, fr;
      logic [63:0] frac;
      es = (exp_size > 3'd4) ? 4 : int'(exp_size);
      w = posit_word;
      d.value_class = p2d_pkg::CLASS_NORMAL;
      if (w == 16'h0000) begin
         d.double_word = 64'd0;
         d.value_class = p2d_pkg::CLASS_ZERO;
         return d;
      end
      if (w == 16'h8000) begin
         d.double_word = p2d_pkg::QNAN_BITS;
         d.value_class = p2d_pkg::CLASS_NAR;
         return d;
      end
      sign = w[15];
      if (sign) w = -w;
      first = w[14];
      run = 0;
      while (run < 15 && w[14-run] == first) run++;
      k = first ? run - 1 : -run;
      rem = (run < 15) ? 14 - run : 0;
      r = w & ((16'd1 << rem) - 16'd1);
      if (rem >= es) begin
         fbits = rem - es;
         ex = r >> fbits;
         fr = r & ((16'd1 << fbits) - 16'd1);
      end else begin
         fbits = 0;
         ex = r << (es - rem);
         fr = 16'd0;
      end
      e = int'(ex) + k * (1 << es) + 1023;
      frac = 64'(fr) << (52 - fbits);
      d.double_word = {sign, e[10:0], frac[51:0]};
      return d;
   endfunction

   function void note_word(logic [15:0] posit_word);
      pending_q.push_back(decode(posit_word));
   endfunction

   function void check_result(logic [63:0] double_word, logic [1:0] value_class);
      decoded_type want;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", double_word);
         return;
      end
      want = pending_q.pop_front();
      if (want.double_word !== double_word || want.value_class !== value_class) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: want %h/%0d got %h/%0d", want.double_word,
                     want.value_class, double_word, value_class);
      end
   endfunction
endclass

module posit_to_double_decoder_tb;
   import p2d_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [ES_BITS-1:0] csr_write_data = '0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   p2d_req_if req ();
   p2d_rsp_if rsp ();

   double_word_scoreboard board = new();

   posit_to_double_decoder dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // Receiver: pick ready at each falling edge, check at the rising edge.
   always @(negedge clock)
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock)
      if (!reset && rsp.valid && rsp.ready)
         board.check_result(rsp.double_word, rsp.value_class);

   // Offer one word and hold it until accepted; drop valid while idling.
   task automatic send_word(logic [15:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.posit_word <= word;
      do @(posedge clock); while (!req.ready);
      board.note_word(word);
      @(negedge clock);
   endtask

   // Drain, let the pipeline settle, then write the exponent size.
   task automatic set_exp_size(logic [2:0] es);
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (board.pending_q.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= es;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.exp_size = es;
   endtask

   // Random word: mostly full random, some with long regime runs.
   function automatic logic [15:0] random_word();
      logic [15:0] w;
      int run;
      w = 16'($urandom);
      if ($urandom_range(3) == 0) begin
         run = $urandom_range(15, 8);
         if (w[14]) w[14 -: 8] = 8'hFF; else w[14 -: 8] = 8'h00;
         if (run == 15) w[14:0] = {15{w[14]}};
      end
      return w;
   endfunction

   initial begin
      logic [15:0] directed[] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001,
         16'h8001, 16'hFFFF, 16'h4000, 16'hC000, 16'h5555, 16'hAAAA,
         16'h7FFE, 16'h0002, 16'h3FFF, 16'h4001, 16'h1234, 16'hFEDC};
      logic [2:0] settings[] = '{3'd0, 3'd4, 3'd1, 3'd2, 3'd3, 3'd7, 3'd5};
      int pcts[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{29, 29}};
      req.valid = 1'b0;
      req.posit_word = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      foreach (settings[s]) begin
         set_exp_size(settings[s]);
         foreach (directed[i]) send_word(directed[i]);
         for (int p = 0; p < 4; p++) begin
            send_idle_pct = pcts[p][0];
            recv_stall_pct = pcts[p][1];
            repeat (42) send_word(random_word());
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_exp_size(3'd0);
      repeat (10) @(negedge clock);
      if (board.mismatches == 0 && board.pending_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Hard stop if the handshake stalls.
   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/p2d_pkg.sv
hw/rtl/p2d_req_if.sv
hw/rtl/p2d_rsp_if.sv
hw/rtl/p2d_decode.sv
hw/rtl/posit_to_double_decoder.sv
dv/posit_to_double_decoder_tb.sv
